// ===== rtl/pcb_pkg.sv =====
// Shared definitions for the palette crossfade blender: request kinds,
// memory geometry and the per-channel blend function. No dependencies.
package pcb_pkg;

  localparam int QUANT_BITS    = 5;
  localparam int PALETTE_SIZE  = 256;
  localparam int PAL_AW        = $clog2(PALETTE_SIZE);
  localparam int TABLE_BITS    = 3 * QUANT_BITS;
  localparam int TABLE_DEPTH   = 1 << TABLE_BITS;
  localparam int COLOR_W       = 24;
  localparam int INDEX_W       = 8;
  localparam int WEIGHT_W      = 9;
  localparam int IN_DATA_W     = 72;
  localparam int IN_USER_W     = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = WEIGHT_W'(256);

  typedef enum logic [1:0] {
    REQ_PIXEL     = 2'd0,
    REQ_WR_PAL_A  = 2'd1,
    REQ_WR_PAL_B  = 2'd2,
    REQ_WR_TABLE  = 2'd3
  } req_kind_t;

  // (256 - w) * a + w * b, shifted down by 8, rewritten as 256 * a + w * (b - a)
  // so that one signed multiply serves each channel.
  function automatic logic [7:0] mix_channel(input logic [7:0] a, input logic [7:0] b,
                                              input logic [WEIGHT_W-1:0] w);
    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = 18'($signed({1'b0, w})) * 18'(diff);
    sum  = $signed({2'b00, a, 8'h00}) + prod;
    return sum[15:8];
  endfunction

endpackage

// ===== rtl/palette_crossfade_blender.sv =====
// Palette crossfade blender top level: two palette RAMs, blend stage and
// inverse color table RAM. Depends on pcb_pkg and pcb_ram.
//
// Channel      | Dir | Handshake                       | Payload
// -------------+-----+---------------------------------+------------------------------
// s_axis       | in  | s_axis_tvalid / s_axis_tready   | tuser: req_type; tdata: pixel
//              |     |                                 |   indices, palette/table writes
// m_axis       | out | m_axis_tvalid / m_axis_tready   | tdata: blended_index
// blend_weight | in  | blend_weight_wr_en              | blend_weight_wr_data
//
// One word is taken every cycle while the skid register is empty. A pixel
// word reaches m_axis by palette read at the accept edge, then blend,
// inverse table read and output register. Write words give no result.
// Reset (rst, synchronous) clears the pipeline valid bits, the output and
// skid valid flags and the weight; memory contents are not cleared.
// A stalled output fills the single skid register, which then holds the whole
// pipeline and drops s_axis_tready until the output drains.
module palette_crossfade_blender
  import pcb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // tdata from bit 0 up: pixel_index_a[8], pixel_index_b[8], palette_entry[8],
  // table_address[15], red[8], green[8], blue[8], table_color[8], one zero pad bit
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser from bit 0 up: req_type[2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata from bit 0 up: blended_index[8]
  output logic [INDEX_W-1:0]    m_axis_tdata,
  input  logic                  blend_weight_wr_en,
  input  logic [WEIGHT_W-1:0]   blend_weight_wr_data
);

  // Unpacked input fields
  req_kind_t          req_type;
  logic [7:0]         pixel_index_a;
  logic [7:0]         pixel_index_b;
  logic [7:0]         palette_entry;
  logic [14:0]        table_address;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         table_color;

  assign req_type      = req_kind_t'(s_axis_tuser);
  assign pixel_index_a = s_axis_tdata[7:0];
  assign pixel_index_b = s_axis_tdata[15:8];
  assign palette_entry = s_axis_tdata[23:16];
  assign table_address = s_axis_tdata[38:24];
  assign red           = s_axis_tdata[46:39];
  assign green         = s_axis_tdata[54:47];
  assign blue          = s_axis_tdata[62:55];
  assign table_color   = s_axis_tdata[70:63];

  // Weight register, clamped to 256 where it is used
  logic [WEIGHT_W-1:0] weight;
  logic [WEIGHT_W-1:0] weight_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (blend_weight_wr_en) begin
      weight <= blend_weight_wr_data;
    end
  end

  assign weight_sat = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;

  // Pipeline advance: the whole pipeline moves together unless the skid
  // register is holding a result.
  logic skid_valid;
  logic [INDEX_W-1:0] skid_data;
  logic advance;
  logic accept;

  assign advance       = !skid_valid;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  // Palette RAMs: writes and reads both happen at the accept edge, so each
  // access lands in arrival order and no forwarding is needed.
  logic [COLOR_W-1:0] pal_a_rd;
  logic [COLOR_W-1:0] pal_b_rd;
  logic [COLOR_W-1:0] wr_color;

  assign wr_color = {red, green, blue};

  pcb_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_pal_a (
    .clk     (clk),
    .wr_en   (accept && (req_type == REQ_WR_PAL_A)),
    .wr_addr (palette_entry[PAL_AW-1:0]),
    .wr_data (wr_color),
    .rd_en   (advance),
    .rd_addr (pixel_index_a[PAL_AW-1:0]),
    .rd_data (pal_a_rd)
  );

  pcb_ram #(.WIDTH(COLOR_W), .DEPTH(PALETTE_SIZE)) u_pal_b (
    .clk     (clk),
    .wr_en   (accept && (req_type == REQ_WR_PAL_B)),
    .wr_addr (palette_entry[PAL_AW-1:0]),
    .wr_data (wr_color),
    .rd_en   (advance),
    .rd_addr (pixel_index_b[PAL_AW-1:0]),
    .rd_data (pal_b_rd)
  );

  // Stage 1: palette colors valid; carry table writes alongside so they
  // reach the inverse table in word order.
  logic                  pix1;
  logic                  tw1;
  logic [TABLE_BITS-1:0] taddr1;
  logic [7:0]            tcolor1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix1 <= 1'b0;
      tw1  <= 1'b0;
    end else if (advance) begin
      pix1 <= accept && (req_type == REQ_PIXEL);
      tw1  <= accept && (req_type == REQ_WR_TABLE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      taddr1  <= table_address[TABLE_BITS-1:0];
      tcolor1 <= table_color;
    end
  end

  // Blend each channel, then keep the top QUANT_BITS of each
  logic [7:0]            mix_r;
  logic [7:0]            mix_g;
  logic [7:0]            mix_b;
  logic [TABLE_BITS-1:0] blend_addr;

  assign mix_r = mix_channel(pal_a_rd[23:16], pal_b_rd[23:16], weight_sat);
  assign mix_g = mix_channel(pal_a_rd[15:8],  pal_b_rd[15:8],  weight_sat);
  assign mix_b = mix_channel(pal_a_rd[7:0],   pal_b_rd[7:0],   weight_sat);
  assign blend_addr = {mix_r[7 -: QUANT_BITS], mix_g[7 -: QUANT_BITS],
                       mix_b[7 -: QUANT_BITS]};

  // Stage 2: inverse table address, either the blended color or a write target
  logic                  pix2;
  logic                  tw2;
  logic [TABLE_BITS-1:0] taddr2;
  logic [7:0]            tcolor2;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix2 <= 1'b0;
      tw2  <= 1'b0;
    end else if (advance) begin
      pix2 <= pix1;
      tw2  <= tw1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      taddr2  <= tw1 ? taddr1 : blend_addr;
      tcolor2 <= tcolor1;
    end
  end

  // Inverse table: one access per stage-2 word, so reads and writes stay in order
  logic [INDEX_W-1:0] table_rd;

  pcb_ram #(.WIDTH(INDEX_W), .DEPTH(TABLE_DEPTH)) u_inv_table (
    .clk     (clk),
    .wr_en   (advance && tw2),
    .wr_addr (taddr2),
    .wr_data (tcolor2),
    .rd_en   (advance),
    .rd_addr (taddr2),
    .rd_data (table_rd)
  );

  // Stage 3: table entry valid
  logic pix3;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix3 <= 1'b0;
    end else if (advance) begin
      pix3 <= pix2;
    end
  end

  // Output register plus skid register. A result arrives only while the
  // skid is empty, so one spare entry is enough.
  logic arrive;

  assign arrive = advance && pix3;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!arrive) begin
        m_axis_tvalid <= 1'b0;
      end
    end else if (!m_axis_tvalid) begin
      if (arrive) begin
        m_axis_tvalid <= 1'b1;
      end
    end else if (arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_data;
      end else if (arrive) begin
        m_axis_tdata <= table_rd;
      end
    end else if (!m_axis_tvalid) begin
      if (arrive) begin
        m_axis_tdata <= table_rd;
      end
    end else if (arrive) begin
      skid_data <= table_rd;
    end
  end

endmodule

// ===== rtl/pcb_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read
// port and a read enable that holds the output. No dependencies.
module pcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== tb/sv/palette_crossfade_blender_checker.sv =====
`timescale 1ns / 1ps
// Checker for the palette crossfade blender: watches the input, output and
// weight channels, predicts each blended index and compares. Depends on pcb_pkg.
module palette_crossfade_blender_checker
  import pcb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [IN_USER_W-1:0] s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [INDEX_W-1:0]   m_axis_tdata,
  input  logic                 blend_weight_wr_en,
  input  logic [WEIGHT_W-1:0]  blend_weight_wr_data,
  output int                   failures,
  output int                   pending
);

  // Input word fields, highest first (tdata bit 71 is padding).
  typedef struct packed {
    logic [7:0]  table_color;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [14:0] table_address;
    logic [7:0]  palette_entry;
    logic [7:0]  index_b;
    logic [7:0]  index_a;
  } request_word_t;

  logic [COLOR_W-1:0]  first_colors  [PALETTE_SIZE];
  logic [COLOR_W-1:0]  second_colors [PALETTE_SIZE];
  logic [INDEX_W-1:0]  inverse_lut   [TABLE_DEPTH];
  logic [WEIGHT_W-1:0] weight = '0;
  logic [INDEX_W-1:0]  expected_index [$];
  int                  mismatches = 0;

  // Blend both colors per channel, keep the top QUANT_BITS of each, red highest.
  function automatic logic [INDEX_W-1:0] predict_index(input logic [7:0] ia,
                                                       input logic [7:0] ib);
    int unsigned          w;
    int unsigned          level;
    logic [TABLE_BITS-1:0] addr;
    w = (weight > WEIGHT_FULL) ? 256 : int'(weight);
    addr = '0;
    for (int ch = 2; ch >= 0; ch--) begin
      level = ((256 - w) * int'(first_colors[ia][8*ch +: 8])
               + w * int'(second_colors[ib][8*ch +: 8])) >> 8;
      addr = {addr[TABLE_BITS-QUANT_BITS-1:0], level[7 -: QUANT_BITS]};
    end
    return inverse_lut[addr];
  endfunction

  always @(posedge clk) begin
    request_word_t      word;
    logic [INDEX_W-1:0] want;
    if (rst) begin
      weight = '0;
      expected_index.delete();
    end else begin
      // Outputs first: a word accepted at this edge cannot answer at the same edge.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_index.size() == 0) begin
          $error("blended_index word with nothing expected: actual %0d", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_index.pop_front();
          if (m_axis_tdata !== want) begin
            $error("blended_index mismatch: expected %0d, actual %0d", want, m_axis_tdata);
            mismatches++;
          end
        end
      end
      if (blend_weight_wr_en) weight = blend_weight_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        word = s_axis_tdata[IN_DATA_W-2:0];
        case (req_kind_t'(s_axis_tuser))
          REQ_PIXEL:    expected_index.push_back(predict_index(word.index_a, word.index_b));
          REQ_WR_PAL_A: first_colors[word.palette_entry] = {word.red, word.green, word.blue};
          REQ_WR_PAL_B: second_colors[word.palette_entry] = {word.red, word.green, word.blue};
          REQ_WR_TABLE: inverse_lut[word.table_address] = word.table_color;
          default: ;
        endcase
      end
    end
    failures <= mismatches;
    pending  <= expected_index.size();
  end

endmodule

// ===== tb/sv/palette_crossfade_blender_test.sv =====
`timescale 1ns / 1ps
// Top of the palette crossfade blender testbench: clock, reset, stimulus with
// random idling and the verdict. Depends on pcb_pkg, the block and its checker.
module palette_crossfade_blender_test;
  import pcb_pkg::*;

  localparam int PHASES        = 8;
  localparam int PHASE_WORDS   = 92;   // random picks per weight setting
  localparam int SETTLE_CYCLES = 8;    // covers the pipeline depth
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int HOLD_SPACING  = 300;  // results between hold-offs

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tdata from bit 0 up: pixel_index_a[8], pixel_index_b[8], palette_entry[8],
  // table_address[15], red[8], green[8], blue[8], table_color[8], zero pad bit
  logic [IN_DATA_W-1:0] s_axis_tdata;
  // tuser from bit 0 up: req_type[2]
  logic [IN_USER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // tdata from bit 0 up: blended_index[8]
  logic [INDEX_W-1:0]   m_axis_tdata;
  logic                 blend_weight_wr_en;
  logic [WEIGHT_W-1:0]  blend_weight_wr_data;
  int                   failures;
  int                   pending;

  // Stream-order shadow of what has been loaded, so that no pixel word ever
  // reads a palette entry or inverse table entry that was never written.
  logic [COLOR_W-1:0]  shadow_a [PALETTE_SIZE];
  logic [COLOR_W-1:0]  shadow_b [PALETTE_SIZE];
  bit                  a_loaded [PALETTE_SIZE];
  bit                  b_loaded [PALETTE_SIZE];
  bit                  lut_loaded [TABLE_DEPTH];
  logic [7:0]          entries_a [$];
  logic [7:0]          entries_b [$];
  logic [WEIGHT_W-1:0] phase_weight = '0;
  bit                  source_calm = 1'b0;

  always #5 clk = ~clk;

  palette_crossfade_blender dut (
    .clk                  (clk),
    .rst                  (rst),
    .s_axis_tvalid        (s_axis_tvalid),
    .s_axis_tready        (s_axis_tready),
    .s_axis_tdata         (s_axis_tdata),
    .s_axis_tuser         (s_axis_tuser),
    .m_axis_tvalid        (m_axis_tvalid),
    .m_axis_tready        (m_axis_tready),
    .m_axis_tdata         (m_axis_tdata),
    .blend_weight_wr_en   (blend_weight_wr_en),
    .blend_weight_wr_data (blend_weight_wr_data)
  );

  palette_crossfade_blender_checker blend_check (
    .clk                  (clk),
    .rst                  (rst),
    .s_axis_tvalid        (s_axis_tvalid),
    .s_axis_tready        (s_axis_tready),
    .s_axis_tdata         (s_axis_tdata),
    .s_axis_tuser         (s_axis_tuser),
    .m_axis_tvalid        (m_axis_tvalid),
    .m_axis_tready        (m_axis_tready),
    .m_axis_tdata         (m_axis_tdata),
    .blend_weight_wr_en   (blend_weight_wr_en),
    .blend_weight_wr_data (blend_weight_wr_data),
    .failures             (failures),
    .pending              (pending)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pause_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(16, 40);
  endfunction

  // Fill every field with noise; callers overwrite the fields that matter.
  function automatic logic [IN_DATA_W-2:0] random_fill();
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    return noise[IN_DATA_W-2:0];
  endfunction

  // Inverse table address that a pixel word will hit under the current weight.
  function automatic logic [TABLE_BITS-1:0] blend_address(input logic [7:0] ia,
                                                          input logic [7:0] ib);
    int unsigned           w;
    int unsigned           level;
    logic [TABLE_BITS-1:0] addr;
    w = (phase_weight > WEIGHT_FULL) ? 256 : int'(phase_weight);
    addr = '0;
    for (int ch = 2; ch >= 0; ch--) begin
      level = ((256 - w) * int'(shadow_a[ia][8*ch +: 8])
               + w * int'(shadow_b[ib][8*ch +: 8])) >> 8;
      addr = {addr[TABLE_BITS-QUANT_BITS-1:0], level[7 -: QUANT_BITS]};
    end
    return addr;
  endfunction

  // Favor the newest entry so that reads land right behind their writes.
  function automatic logic [7:0] pick_entry(input bit second);
    if (second) begin
      if ($urandom_range(3) == 0) return entries_b[$];
      return entries_b[$urandom_range(entries_b.size() - 1)];
    end
    if ($urandom_range(3) == 0) return entries_a[$];
    return entries_a[$urandom_range(entries_a.size() - 1)];
  endfunction

  // Offer one word, hold it until accepted, then idle for a while. Call at a
  // rising edge; valid stays high into the next word when there is no gap.
  task automatic send_word(input req_kind_t kind, input logic [IN_DATA_W-2:0] fields);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, fields};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = source_calm ? 0 : pause_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_palette(input bit second, input logic [7:0] entry,
                               input logic [COLOR_W-1:0] rgb);
    logic [IN_DATA_W-2:0] fields;
    fields = random_fill();
    fields[23:16] = entry;
    fields[46:39] = rgb[23:16];
    fields[54:47] = rgb[15:8];
    fields[62:55] = rgb[7:0];
    if (second) begin
      shadow_b[entry] = rgb;
      if (!b_loaded[entry]) entries_b.push_back(entry);
      b_loaded[entry] = 1'b1;
      send_word(REQ_WR_PAL_B, fields);
    end else begin
      shadow_a[entry] = rgb;
      if (!a_loaded[entry]) entries_a.push_back(entry);
      a_loaded[entry] = 1'b1;
      send_word(REQ_WR_PAL_A, fields);
    end
  endtask

  task automatic write_lut(input logic [TABLE_BITS-1:0] addr, input logic [7:0] color);
    logic [IN_DATA_W-2:0] fields;
    fields = random_fill();
    fields[38:24] = addr;
    fields[70:63] = color;
    lut_loaded[addr] = 1'b1;
    send_word(REQ_WR_TABLE, fields);
  endtask

  // Load the inverse table entry first if this pixel would hit an empty one.
  task automatic send_pixel(input logic [7:0] ia, input logic [7:0] ib);
    logic [IN_DATA_W-2:0]  fields;
    logic [TABLE_BITS-1:0] addr;
    addr = blend_address(ia, ib);
    if (!lut_loaded[addr]) write_lut(addr, 8'($urandom()));
    fields = random_fill();
    fields[7:0]  = ia;
    fields[15:8] = ib;
    send_word(REQ_PIXEL, fields);
  endtask

  // Write the weight with the block idle; the checker sees the same edge.
  task automatic set_weight(input logic [WEIGHT_W-1:0] w);
    blend_weight_wr_en   <= 1'b1;
    blend_weight_wr_data <= w;
    phase_weight = w;
    @(posedge clk);
    blend_weight_wr_en <= 1'b0;
  endtask

  // Drop valid, drain every expected result, then let write words settle.
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int words);
    int         roll;
    bit         second;
    logic [7:0] entry;
    repeat (words) begin
      roll = $urandom_range(99);
      if (roll < 50) begin
        send_pixel(pick_entry(1'b0), pick_entry(1'b1));
      end else if (roll < 80) begin
        second = (roll >= 65);
        entry = 8'($urandom());
        write_palette(second, entry, 24'($urandom()));
        // Read the fresh entry right away now and then.
        if ($urandom_range(9) < 3) begin
          if (second) send_pixel(pick_entry(1'b0), entry);
          else send_pixel(entry, pick_entry(1'b1));
        end
      end else begin
        write_lut(15'($urandom()), 8'($urandom()));
      end
    end
  endtask

  // Receiver: ready runs of random length with stalls between them, and a
  // long hold-off now and then so the block backs up into its input.
  initial begin : sink
    int delivered;
    int next_hold;
    int run;
    int stall;
    delivered = 0;
    next_hold = 150;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (delivered >= next_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        next_hold = delivered + HOLD_SPACING;
      end
      m_axis_tready <= 1'b1;
      run = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 12);
      repeat (run) begin
        @(posedge clk);
        if (m_axis_tvalid && m_axis_tready) delivered++;
      end
      stall = pause_length();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [WEIGHT_W-1:0] phase_weights [PHASES];
    logic [7:0]          spare;
    rst                  <= 1'b1;
    s_axis_tvalid        <= 1'b0;
    s_axis_tdata         <= '0;
    s_axis_tuser         <= REQ_PIXEL;
    blend_weight_wr_en   <= 1'b0;
    blend_weight_wr_data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: black and white corners at half weight, then writes followed
    // at once by reads of the same entry, in both directions.
    set_weight(9'd128);
    write_palette(1'b0, 8'd0,   24'h000000);
    write_palette(1'b1, 8'd0,   24'hFFFFFF);
    write_palette(1'b0, 8'd255, 24'hFFFFFF);
    write_palette(1'b1, 8'd255, 24'h000000);
    write_lut(15'h0000, 8'h00);
    write_lut(15'h7FFF, 8'hFF);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    write_palette(1'b0, 8'd7, 24'($urandom()));
    send_pixel(8'd7, 8'd0);
    write_palette(1'b1, 8'd7, 24'($urandom()));
    send_pixel(8'd0, 8'd7);
    // Overwrite the all-white table entry just before and just after a read.
    spare = 8'($urandom());
    write_lut(15'h7FFF, spare);
    send_pixel(8'd255, 8'd0);
    write_lut(15'h7FFF, ~spare);
    send_pixel(8'd255, 8'd0);
    finish_phase();

    // Random: weight extremes, saturation above full weight, and in-between.
    phase_weights = '{9'd0, 9'd256, 9'd511, 9'd257, 9'd1, 9'd255,
                      9'($urandom_range(2, 254)), 9'($urandom_range(258, 510))};
    for (int p = 0; p < PHASES; p++) begin
      source_calm = (p % 3 == 2);
      set_weight(phase_weights[p]);
      random_phase(PHASE_WORDS);
      finish_phase();
    end

    if (failures == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
